// ----- rtl/otca_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package otca_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  localparam int RULE_W    = 18;
  localparam int DIM_W     = 7;
  localparam int COLUMN_W  = 6;
  localparam int ROW_W     = 6;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [RULE_W-1:0] RULE_RESET = RULE_W'(224);
  localparam logic [DIM_W-1:0]  DIM_RESET  = DIM_W'(64);

  localparam logic [1:0] REG_RULE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADV,
    ST_RESP
  } state_t;

  // one column of the three-row window held by a cell
  typedef struct packed {
    logic up;
    logic mid;
    logic dn;
  } col_bits_t;

endpackage
`default_nettype wire

// ----- rtl/otca_row_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
module otca_row_mem #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [$clog2(ROWS)-1:0] wr_addr,
  input  wire logic [COLS-1:0]         wr_mask,
  input  wire logic [COLS-1:0]         wr_data,
  input  wire logic                    rd_en,
  input  wire logic [$clog2(ROWS)-1:0] rd_addr,
  output logic      [COLS-1:0]         rd_data
);

  logic [COLS-1:0] mem [ROWS];

  // bit-enable write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int b = 0; b < COLS; b++) begin
        if (wr_mask[b]) begin
          mem[wr_addr][b] <= wr_data[b];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/otca_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module otca_cell (
  input  wire logic                          clk,
  input  wire logic                          shift_en,
  input  wire logic                          in_bit,
  input  wire otca_pkg::col_bits_t           left,
  input  wire otca_pkg::col_bits_t           right,
  input  wire logic [otca_pkg::RULE_W-1:0]   rule,
  output otca_pkg::col_bits_t                col_q,
  output logic                               next_bit
);

  import otca_pkg::*;

  col_bits_t   col_r;
  col_bits_t   col_nxt;
  logic [3:0]  count;
  logic [4:0]  rule_idx;
  logic [31:0] rule_ext;

  always_comb begin
    col_nxt.up  = col_r.mid;
    col_nxt.mid = col_r.dn;
    col_nxt.dn  = in_bit;
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r <= col_nxt;
    end
  end

  always_comb begin
    count = 4'(left.up) + 4'(left.mid) + 4'(left.dn)
          + 4'(col_r.up) + 4'(col_r.dn)
          + 4'(right.up) + 4'(right.mid) + 4'(right.dn);
    rule_idx = {count, col_r.mid};
    rule_ext = 32'(rule);
    next_bit = rule_ext[rule_idx];
  end

  assign col_q = col_r;

endmodule
`default_nettype wire

// ----- rtl/otca_cell_row.sv -----
`timescale 1ns / 1ps
`default_nettype none
module otca_cell_row #(
  parameter int MAX_WIDTH = otca_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           shift_en,
  input  wire logic [MAX_WIDTH-1:0]           row_in,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0] width_eff,
  input  wire logic [otca_pkg::RULE_W-1:0]    rule,
  output logic      [MAX_WIDTH-1:0]           next_row
);

  import otca_pkg::*;

  localparam int CIW = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH+1);

  col_bits_t cols      [MAX_WIDTH];
  col_bits_t left_of   [MAX_WIDTH];
  col_bits_t right_of  [MAX_WIDTH];
  col_bits_t wrap_left;

  // leftmost cell sees the last active column across the wrap
  assign wrap_left = cols[CIW'(width_eff - WW'(1))];

  for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_cell
    if (c == 0) begin : g_first
      assign left_of[c] = wrap_left;
    end else begin : g_inner
      assign left_of[c] = cols[c-1];
    end

    if (c == MAX_WIDTH-1) begin : g_last
      assign right_of[c] = cols[0];
    end else begin : g_mid
      assign right_of[c] = (width_eff == WW'(c+1)) ? cols[0] : cols[c+1];
    end

    otca_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .in_bit   (row_in[c]),
      .left     (left_of[c]),
      .right    (right_of[c]),
      .rule     (rule),
      .col_q    (cols[c]),
      .next_bit (next_row[c])
    );
  end

endmodule
`default_nettype wire

// ----- rtl/outer_totalistic_cellular_automaton_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Life-like cellular automaton on a torus of grid_height rows by grid_width columns
// (saturated to 3..MAX_HEIGHT and 3..MAX_WIDTH). Each input transaction writes a cell,
// reads a cell or advances one generation, and returns exactly one result transaction
// (read_value, zero except on a read of an active cell). Cells live in a row memory of
// MAX_HEIGHT rows by MAX_WIDTH bits; after reset a clearing pass zeroes it one row at a
// time and no transaction is accepted meanwhile. A write or read goes from acceptance
// through the response state to a registered result. An advance streams one row per
// cycle from the row memory through a row of MAX_WIDTH cells holding a three-row
// window and writes each new row back in place. One transaction is in work at a time;
// the next is accepted while the previous result still waits on the output.
module outer_totalistic_cellular_automaton_unit #(
  parameter int MAX_WIDTH  = otca_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = otca_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,

  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          in_operation,
  input  wire logic [otca_pkg::COLUMN_W-1:0]       in_column,
  input  wire logic [otca_pkg::ROW_W-1:0]          in_row,
  input  wire logic                                in_write_value,

  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_read_value,

  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [otca_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [otca_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [otca_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                     pready
);

  import otca_pkg::*;

  localparam int CIW  = $clog2(MAX_WIDTH);
  localparam int RAW  = $clog2(MAX_HEIGHT);
  localparam int WW   = $clog2(MAX_WIDTH+1);
  localparam int HW   = $clog2(MAX_HEIGHT+1);
  localparam int SW   = $clog2(MAX_HEIGHT+4);
  localparam int WCW  = (WW > DIM_W) ? WW : DIM_W;
  localparam int HCW  = (HW > DIM_W) ? HW : DIM_W;
  localparam int ICW  = (WW > COLUMN_W) ? WW : COLUMN_W;
  localparam int IRW  = (HW > ROW_W) ? HW : ROW_W;

  // configuration registers
  logic [RULE_W-1:0] rule_r, rule_nxt;
  logic [DIM_W-1:0]  width_r, width_nxt;
  logic [DIM_W-1:0]  height_r, height_nxt;
  logic              cfg_wr;

  // control
  state_t            state_r, state_nxt;
  logic [RAW-1:0]    clr_r, clr_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              rd_sel_r, rd_sel_nxt;

  // payload
  logic              out_read_value_r, out_read_value_nxt;
  logic [CIW-1:0]    col_r, col_nxt;
  logic [MAX_WIDTH-1:0] row0_r, row0_nxt;

  // datapath
  logic [WCW-1:0]    width_ext;
  logic [HCW-1:0]    height_ext;
  logic [WW-1:0]     width_eff;
  logic [HW-1:0]     height_eff;
  logic              in_grid;
  logic [CIW-1:0]    col_idx;
  logic [RAW-1:0]    row_idx;
  logic [MAX_WIDTH-1:0] active_mask;
  logic [SW-1:0]     h_step;

  logic                 mem_wr_en;
  logic [RAW-1:0]       mem_wr_addr;
  logic [MAX_WIDTH-1:0] mem_wr_mask;
  logic [MAX_WIDTH-1:0] mem_wr_data;
  logic                 mem_rd_en;
  logic [RAW-1:0]       mem_rd_addr;
  logic [MAX_WIDTH-1:0] mem_rd_data;

  logic                 shift_en;
  logic [MAX_WIDTH-1:0] row_src;
  logic [MAX_WIDTH-1:0] next_row;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    rule_nxt   = rule_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RULE:   rule_nxt   = pwdata[RULE_W-1:0];
        REG_WIDTH:  width_nxt  = pwdata[DIM_W-1:0];
        REG_HEIGHT: height_nxt = pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RULE:   prdata = CFG_DATA_W'(rule_r);
      REG_WIDTH:  prdata = CFG_DATA_W'(width_r);
      REG_HEIGHT: prdata = CFG_DATA_W'(height_r);
      default:    prdata = '0;
    endcase
  end

  // grid size saturation
  always_comb begin
    width_ext  = WCW'(width_r);
    height_ext = HCW'(height_r);
    if (width_ext < WCW'(3)) begin
      width_eff = WW'(3);
    end else if (width_ext > WCW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(width_ext);
    end
    if (height_ext < HCW'(3)) begin
      height_eff = HW'(3);
    end else if (height_ext > HCW'(MAX_HEIGHT)) begin
      height_eff = HW'(MAX_HEIGHT);
    end else begin
      height_eff = HW'(height_ext);
    end
  end

  assign in_grid = (ICW'(in_column) < ICW'(width_eff)) && (IRW'(in_row) < IRW'(height_eff));
  assign col_idx = CIW'(in_column);
  assign row_idx = RAW'(in_row);
  assign h_step  = SW'(height_eff);

  for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_mask
    assign active_mask[c] = (WW'(c) < width_eff);
  end

  assign in_ready = (state_r == ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt          = state_r;
    clr_nxt            = clr_r;
    step_nxt           = step_r;
    out_valid_nxt      = out_valid_r & ~out_ready;
    out_read_value_nxt = out_read_value_r;
    rd_sel_nxt         = rd_sel_r;
    col_nxt            = col_r;
    row0_nxt           = row0_r;
    mem_wr_en          = 1'b0;
    mem_wr_addr        = clr_r;
    mem_wr_mask        = '1;
    mem_wr_data        = '0;
    mem_rd_en          = 1'b0;
    mem_rd_addr        = row_idx;
    shift_en           = 1'b0;
    row_src            = mem_rd_data;

    unique case (state_r)
      ST_CLEAR: begin
        mem_wr_en = 1'b1;
        clr_nxt   = clr_r + RAW'(1);
        if (clr_r == RAW'(MAX_HEIGHT-1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          col_nxt    = col_idx;
          rd_sel_nxt = 1'b0;
          state_nxt  = ST_RESP;
          unique case (in_operation)
            OP_WRITE: begin
              mem_wr_en   = in_grid;
              mem_wr_addr = row_idx;
              mem_wr_mask = MAX_WIDTH'(1) << col_idx;
              mem_wr_data = {MAX_WIDTH{in_write_value}};
            end
            OP_READ: begin
              mem_rd_en  = 1'b1;
              rd_sel_nxt = in_grid;
            end
            OP_ADVANCE: begin
              step_nxt  = '0;
              state_nxt = ST_ADV;
            end
            default: ;
          endcase
        end
      end

      ST_ADV: begin
        step_nxt = step_r + SW'(1);
        // rows are fetched as last, 0, 1, ..., last; row 0 is replayed from a copy
        if (step_r <= h_step) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = (step_r == '0) ? RAW'(height_eff - HW'(1)) : RAW'(step_r - SW'(1));
        end
        if (step_r == SW'(2)) begin
          row0_nxt = mem_rd_data;
        end
        if ((step_r != '0) && (step_r <= h_step + SW'(2))) begin
          shift_en = 1'b1;
          row_src  = (step_r == h_step + SW'(2)) ? row0_r : mem_rd_data;
        end
        if (step_r >= SW'(4)) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = RAW'(step_r - SW'(4));
          mem_wr_mask = active_mask;
          mem_wr_data = next_row;
        end
        if (step_r == h_step + SW'(3)) begin
          state_nxt = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_read_value_nxt = rd_sel_r & mem_rd_data[col_r];
          state_nxt          = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      rd_sel_r    <= 1'b0;
      rule_r      <= RULE_RESET;
      width_r     <= DIM_RESET;
      height_r    <= DIM_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      rd_sel_r    <= rd_sel_nxt;
      rule_r      <= rule_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_read_value_r <= out_read_value_nxt;
    col_r            <= col_nxt;
    row0_r           <= row0_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;

  otca_row_mem #(
    .ROWS (MAX_HEIGHT),
    .COLS (MAX_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_mask (mem_wr_mask),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  otca_cell_row #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cells (
    .clk       (clk),
    .shift_en  (shift_en),
    .row_in    (row_src),
    .width_eff (width_eff),
    .rule      (rule_r),
    .next_row  (next_row)
  );

endmodule
`default_nettype wire

// ----- tb/automaton_checker.sv -----
`timescale 1ns / 1ps
module automaton_checker
  import otca_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire logic [1:0]            in_operation,
  input  wire logic [COLUMN_W-1:0]   in_column,
  input  wire logic [ROW_W-1:0]      in_row,
  input  wire logic                  in_write_value,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic                  out_read_value,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  input  wire logic                  pready,
  output int                         pending,
  output int                         failures
);

  logic [MAX_WIDTH_DEF-1:0] cells [MAX_HEIGHT_DEF];
  logic [RULE_W-1:0]        rule_reg;
  logic [DIM_W-1:0]         width_reg;
  logic [DIM_W-1:0]         height_reg;
  logic                     read_values_due [$];
  int                       mismatch_count;

  function automatic int clip_dim(input logic [DIM_W-1:0] value, input int limit);
    if (value < 3) return 3;
    if (value > limit) return limit;
    return int'(value);
  endfunction

  function automatic void next_generation();
    logic [MAX_WIDTH_DEF-1:0] fresh [MAX_HEIGHT_DEF];
    int w;
    int h;
    int live;
    int rr;
    int cc;
    w = clip_dim(width_reg, MAX_WIDTH_DEF);
    h = clip_dim(height_reg, MAX_HEIGHT_DEF);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        live = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              rr = (r + dr + h) % h;
              cc = (c + dc + w) % w;
              live += cells[rr][cc];
            end
          end
        end
        fresh[r][c] = rule_reg[2 * live + cells[r][c]];
      end
    end
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        cells[r][c] = fresh[r][c];
      end
    end
  endfunction

  function automatic logic apply_operation(input logic [1:0] op, input int col, input int row,
                                           input logic value);
    logic active;
    logic cell_state;
    active = col < clip_dim(width_reg, MAX_WIDTH_DEF) && row < clip_dim(height_reg, MAX_HEIGHT_DEF);
    cell_state = 1'b0;
    case (op)
      OP_WRITE: begin
        if (active) cells[row][col] = value;
      end
      OP_READ: begin
        if (active) cell_state = cells[row][col];
      end
      OP_ADVANCE: begin
        next_generation();
      end
      default: begin
      end
    endcase
    return cell_state;
  endfunction

  always @(posedge clk) begin
    logic expected_bit;
    if (!rst_n) begin
      for (int r = 0; r < MAX_HEIGHT_DEF; r++) cells[r] = '0;
      rule_reg = RULE_RESET;
      width_reg = DIM_RESET;
      height_reg = DIM_RESET;
      read_values_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:2])
          REG_RULE:   rule_reg = pwdata[RULE_W-1:0];
          REG_WIDTH:  width_reg = pwdata[DIM_W-1:0];
          REG_HEIGHT: height_reg = pwdata[DIM_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready) begin
        if (read_values_due.size() == 0) begin
          $error("read_value: expected none, actual %0b", out_read_value);
          mismatch_count++;
        end else begin
          expected_bit = read_values_due.pop_front();
          if (out_read_value !== expected_bit) begin
            $error("read_value: expected %0b, actual %0b", expected_bit, out_read_value);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready)
        read_values_due.push_back(apply_operation(in_operation, int'(in_column), int'(in_row),
                                                  in_write_value));
    end
    pending <= read_values_due.size();
    failures <= mismatch_count;
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import otca_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = MAX_HEIGHT_DEF + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS = 15;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = OP_WRITE;
  logic [COLUMN_W-1:0] in_column = '0;
  logic [ROW_W-1:0] in_row = '0;
  logic in_write_value = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_read_value;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;
  int pending;
  int failures;

  int burst_left;
  int act_w = MAX_WIDTH_DEF;
  int act_h = MAX_HEIGHT_DEF;
  int ready_mode;
  int ready_left;
  int quiet_cycles;

  always #1 clk = ~clk;

  outer_totalistic_cellular_automaton_unit dut (.*);

  automaton_checker checker_inst (.*);

  // receiver stall pattern
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_left = $urandom_range(4, 48);
    end
    ready_left = ready_left - 1;
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pwrite))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] op, input int col, input int row, input logic value);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_column <= COLUMN_W'(col);
    in_row <= ROW_W'(row);
    in_write_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left = burst_left - 1;
  endtask

  task automatic send_random_item();
    int pick;
    logic [1:0] op;
    int col;
    int row;
    pick = $urandom_range(0, 99);
    if (pick < 40) op = OP_WRITE;
    else if (pick < 68) op = OP_READ;
    else if (pick < 93) op = OP_ADVANCE;
    else op = OP_SPARE;
    if ($urandom_range(0, 99) < 85) begin
      col = $urandom_range(0, act_w - 1);
      row = $urandom_range(0, act_h - 1);
    end else begin
      col = $urandom_range(0, 63);
      row = $urandom_range(0, 63);
    end
    send_item(op, col, row, $urandom_range(0, 9) < 7);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [RULE_W-1:0] rule, input logic [DIM_W-1:0] w,
                           input logic [DIM_W-1:0] h);
    drain();
    reg_write(REG_RULE, CFG_DATA_W'(rule));
    reg_write(REG_WIDTH, CFG_DATA_W'(w));
    reg_write(REG_HEIGHT, CFG_DATA_W'(h));
    act_w = (w < 3) ? 3 : (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(w);
    act_h = (h < 3) ? 3 : (h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(h);
    repeat (PHASE_ITEMS) send_random_item();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);

    // cleared grid, blinker across the wrap corner, isolated cell
    send_item(OP_READ, 0, 0, 1'b0);
    send_item(OP_READ, 63, 63, 1'b1);
    send_item(OP_WRITE, 63, 0, 1'b1);
    send_item(OP_WRITE, 0, 0, 1'b1);
    send_item(OP_WRITE, 1, 0, 1'b1);
    send_item(OP_WRITE, 63, 63, 1'b1);
    send_item(OP_WRITE, 63, 63, 1'b0);
    send_item(OP_WRITE, 32, 32, 1'b1);
    send_item(OP_SPARE, 63, 63, 1'b1);
    send_item(OP_READ, 63, 0, 1'b0);
    send_item(OP_ADVANCE, 0, 0, 1'b0);
    send_item(OP_READ, 0, 63, 1'b0);
    send_item(OP_READ, 0, 1, 1'b0);
    send_item(OP_READ, 63, 0, 1'b0);
    send_item(OP_READ, 32, 32, 1'b0);
    send_item(OP_ADVANCE, 63, 63, 1'b1);
    send_item(OP_READ, 63, 0, 1'b0);
    send_item(OP_READ, 1, 0, 1'b0);

    run_phase(RULE_W'($urandom_range(0, 18'h3FFFF)), 7'd3, 7'd3);
    run_phase('0, 7'd0, 7'd2);
    run_phase('1, 7'd127, 7'd127);
    drain();
    reg_write(REG_SPARE, '1);
    run_phase(RULE_RESET, 7'd5, 7'd7);
    run_phase(RULE_W'($urandom_range(0, 18'h3FFFF)), DIM_W'($urandom_range(3, 16)),
              DIM_W'($urandom_range(3, 16)));
    run_phase(RULE_W'($urandom_range(0, 18'h3FFFF)), 7'd64, 7'd3);
    run_phase(RULE_W'($urandom_range(0, 18'h3FFFF)), 7'd3, 7'd64);
    run_phase(RULE_RESET, DIM_RESET, DIM_RESET);
    drain();

    if (failures == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
